>>> rtl/core/strict_priority_bandwidth_allocator_core_macros.svh
// assertion macros for the bandwidth allocator core
// expects clk and rst_n in the scope where a macro is used
`ifndef STRICT_PRIORITY_BANDWIDTH_ALLOCATOR_CORE_MACROS_SVH
`define STRICT_PRIORITY_BANDWIDTH_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define SPBA_ASSERT_IMP(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication
`define SPBA_ASSERT_NXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

>>> rtl/core/spba_pkg.sv
// shared types and constants of the bandwidth allocator core
// no dependencies
`default_nettype none

package spba_pkg;

    localparam int RATE_W   = 16;
    localparam int PRIO_W   = 3;
    localparam int SLOTF_W  = 4;
    localparam int REQ_W    = 20;
    localparam int DEMAND_W = PRIO_W + RATE_W;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 80;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIRED_BUDGET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIRELESS_BUDGET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_WIRELESS   = 2'd2;

    localparam logic [RATE_W-1:0] WIRED_DEFAULT    = 16'd4800;
    localparam logic [RATE_W-1:0] WIRELESS_DEFAULT = 16'd1280;
    localparam logic [RATE_W-1:0] MIN_REMAIN       = 16'd8;
    localparam logic [REQ_W-1:0]  REQ_MAX          = 20'hFFFFF;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [RATE_W-1:0] rate;
    } demand_t;

endpackage

`default_nettype wire

>>> rtl/core/strict_priority_bandwidth_allocator_core.sv
// strict priority bandwidth allocator, top level
// uses spba_pkg, spba_ram and the assertion macro header
//
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata slot/prio/rate/enable, tuser cmd
// m_axis    out  m_axis_tvalid/tready      tdata grant fields, tuser no_demand, tlast
// cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// a slot write is taken while idle; the sum pass of a compute visits every slot and reads each
// active slot, then the priorities are stepped up to the highest used one, with a scan over
// the slots for each used priority, as every active slot is read and its priority compared
// on each scan; with no demand, S_NONE puts out the word after the sum pass
// active flags sit in flops cleared by reset; no clearing pass
// the scan holds in S_EVAL while the output word waits on m_axis_tready
`default_nettype none
`include "strict_priority_bandwidth_allocator_core_macros.svh"

module strict_priority_bandwidth_allocator_core
    import spba_pkg::*;
#(
    parameter int SLOT_COUNT      = 16,
    parameter int PRIORITY_LEVELS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // slot[3:0], priority_req[6:4], rate[22:7], enable[23]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[0]
    input  wire logic [0:0]            s_axis_tuser,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // grant_slot[3:0], grant_priority[6:4], grant_rate[22:7], degraded[23],
    // total_budget[39:24], requested_total[59:40], used_total[75:60]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // no_demand[0]
    output logic [0:0]                 m_axis_tuser,
    output logic                       m_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [RATE_W-1:0]     cfg_data
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOT_COUNT - 1);
    localparam logic [PRIO_W-1:0] TOP_PRIO = PRIO_W'((1 << PRIO_W) - 1);
    localparam logic [PRIO_W-1:0] CLAMP_PRIO = PRIO_W'(PRIORITY_LEVELS - 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SUM      = 3'd1;
    localparam logic [2:0] S_SUM_DATA = 3'd2;
    localparam logic [2:0] S_PRIO     = 3'd3;
    localparam logic [2:0] S_SCAN     = 3'd4;
    localparam logic [2:0] S_EVAL     = 3'd5;
    localparam logic [2:0] S_NONE     = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic [SW-1:0]           idx_reg, idx_next;
    logic [PRIO_W-1:0]       p_reg, p_next;
    logic [(1<<PRIO_W)-1:0]  mask_reg, mask_next;
    logic [SW-1:0]           lslot_reg, lslot_next;
    logic [PRIO_W-1:0]       lprio_reg, lprio_next;
    logic [REQ_W-1:0]        req_reg, req_next;
    logic [RATE_W-1:0]       used_reg, used_next;
    logic [RATE_W-1:0]       budget_reg, budget_next;
    logic [SLOT_COUNT-1:0]   valid_reg, valid_next;

    logic [RATE_W-1:0]       wired_reg, wired_next;
    logic [RATE_W-1:0]       wireless_reg, wireless_next;
    logic                    mode_reg, mode_next;

    logic                    ovalid_reg, ovalid_next;
    logic [OUT_DATA_W-1:0]   odata_reg, odata_next;
    logic                    ouser_reg, ouser_next;
    logic                    olast_reg, olast_next;

    // input fields
    logic [SLOTF_W-1:0] in_slot;
    logic [PRIO_W-1:0]  in_prio;
    logic [RATE_W-1:0]  in_rate;
    logic               in_en;
    logic               in_acc;

    // ram
    logic               wr_en, rd_en;
    logic [SW-1:0]      wr_addr;
    demand_t            wr_data, rd_data;

    // datapath
    logic               out_free;
    logic [REQ_W:0]     req_sum;
    logic [RATE_W:0]    used_sum;
    logic [RATE_W-1:0]  remain, grant;
    logic               deg, is_last;

    assign in_slot = s_axis_tdata[3:0];
    assign in_prio = s_axis_tdata[6:4];
    assign in_rate = s_axis_tdata[22:7];
    assign in_en   = s_axis_tdata[23];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign out_free      = !ovalid_reg || m_axis_tready;

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;
    assign m_axis_tlast  = olast_reg;

    assign wr_en   = in_acc && (s_axis_tuser[0] == CMD_WRITE)
                     && (32'(in_slot) < SLOT_COUNT);
    assign wr_addr = SW'(in_slot);
    assign wr_data.rate = in_rate;
    assign wr_data.prio = (32'(in_prio) >= PRIORITY_LEVELS) ? CLAMP_PRIO : in_prio;

    assign rd_en = ((state_reg == S_SUM) || (state_reg == S_SCAN)) && valid_reg[idx_reg];

    spba_ram #(
        .WIDTH (DEMAND_W),
        .DEPTH (SLOT_COUNT)
    ) u_demand_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // shared add / compare unit
    always_comb
    begin
        req_sum  = {1'b0, req_reg} + (REQ_W+1)'(rd_data.rate);
        used_sum = {1'b0, used_reg} + {1'b0, rd_data.rate};
        remain   = budget_reg - used_reg;
        if (used_sum > {1'b0, budget_reg})
        begin
            deg   = 1'b1;
            grant = (remain > MIN_REMAIN) ? remain : '0;
        end
        else
        begin
            deg   = 1'b0;
            grant = rd_data.rate;
        end
        is_last = (idx_reg == lslot_reg) && (p_reg == lprio_reg);
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        p_next        = p_reg;
        mask_next     = mask_reg;
        lslot_next    = lslot_reg;
        lprio_next    = lprio_reg;
        req_next      = req_reg;
        used_next     = used_reg;
        budget_next   = budget_reg;
        valid_next    = valid_reg;
        wired_next    = wired_reg;
        wireless_next = wireless_reg;
        mode_next     = mode_reg;
        ovalid_next   = ovalid_reg && !m_axis_tready;
        odata_next    = odata_reg;
        ouser_next    = ouser_reg;
        olast_next    = olast_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WIRED_BUDGET:    wired_next    = (cfg_data == '0) ? WIRED_DEFAULT : cfg_data;
                CFG_WIRELESS_BUDGET: wireless_next = (cfg_data == '0) ? WIRELESS_DEFAULT
                                                                      : cfg_data;
                CFG_MODE_WIRELESS:   mode_next     = cfg_data[0];
                default:             ;
            endcase
        end

        if (wr_en)
        begin
            valid_next[wr_addr] = in_en && (in_rate != '0);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (s_axis_tuser[0] == CMD_COMPUTE))
                begin
                    budget_next = mode_reg ? wireless_reg : wired_reg;
                    req_next    = '0;
                    used_next   = '0;
                    mask_next   = '0;
                    idx_next    = '0;
                    p_next      = '0;
                    state_next  = S_SUM;
                end
            end
            S_SUM:
            begin
                if (valid_reg[idx_reg])
                begin
                    state_next = S_SUM_DATA;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = (mask_reg == '0) ? S_NONE : S_PRIO;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SUM_DATA:
            begin
                req_next = (req_sum > {1'b0, REQ_MAX}) ? REQ_MAX : req_sum[REQ_W-1:0];
                mask_next[rd_data.prio] = 1'b1;
                // latest slot in grant order is the one that carries tlast
                if ((mask_reg == '0) || (rd_data.prio >= lprio_reg))
                begin
                    lslot_next = idx_reg;
                    lprio_next = rd_data.prio;
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_PRIO;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SUM;
                end
            end
            S_PRIO:
            begin
                if (mask_reg[p_reg])
                begin
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
                else if (p_reg == TOP_PRIO)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                if (valid_reg[idx_reg])
                begin
                    state_next = S_EVAL;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = (p_reg == TOP_PRIO) ? S_IDLE : S_PRIO;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_EVAL:
            begin
                if (rd_data.prio != p_reg || out_free)
                begin
                    if (rd_data.prio == p_reg)
                    begin
                        used_next   = used_reg + grant;
                        ovalid_next = 1'b1;
                        ouser_next  = 1'b0;
                        olast_next  = is_last;
                        odata_next  = {4'd0, used_reg + grant, req_reg, budget_reg, deg, grant,
                                       p_reg, SLOTF_W'(idx_reg)};
                    end
                    if ((rd_data.prio == p_reg) && is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = (p_reg == TOP_PRIO) ? S_IDLE : S_PRIO;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_NONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ouser_next  = 1'b1;
                    olast_next  = 1'b1;
                    odata_next  = {40'd0, budget_reg, 24'd0};
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            wired_reg    <= WIRED_DEFAULT;
            wireless_reg <= WIRELESS_DEFAULT;
            mode_reg     <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            wired_reg    <= wired_next;
            wireless_reg <= wireless_next;
            mode_reg     <= mode_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        p_reg      <= p_next;
        mask_reg   <= mask_next;
        lslot_reg  <= lslot_next;
        lprio_reg  <= lprio_next;
        req_reg    <= req_next;
        used_reg   <= used_next;
        budget_reg <= budget_next;
        odata_reg  <= odata_next;
        ouser_reg  <= ouser_next;
        olast_reg  <= olast_next;
    end

    `SPBA_ASSERT_IMP(a_used_in_budget, m_axis_tvalid, m_axis_tdata[75:60] <= m_axis_tdata[39:24], "used total above budget")
    `SPBA_ASSERT_IMP(a_none_is_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast, "no-demand word not last")
    `SPBA_ASSERT_IMP(a_grant_in_used, m_axis_tvalid, m_axis_tdata[22:7] <= m_axis_tdata[75:60], "grant above used total")
    `SPBA_ASSERT_IMP(a_full_grant_nonzero, m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tdata[23], m_axis_tdata[22:7] != '0, "full grant is zero")
    `SPBA_ASSERT_NXT(a_compute_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser[0], !s_axis_tready, "ready right after compute")

endmodule

`default_nettype wire

>>> rtl/core/spba_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module spba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sim/strict_priority_bandwidth_allocator_core_test.sv
// self-checking testbench for the strict priority bandwidth allocator core
// drives slot writes and compute requests, predicts grant words in-line or takes them from the plan
// depends on spba_pkg and strict_priority_bandwidth_allocator_core
`timescale 1ns / 100ps

module strict_priority_bandwidth_allocator_core_test;
    import spba_pkg::*;

    localparam int SLOTS        = 16;
    localparam int LEVELS       = 8;
    localparam int DRAIN_CYCLES = 256;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 55;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [SLOTF_W-1:0] slot;
        logic [PRIO_W-1:0]  prio;
        logic [RATE_W-1:0]  grant;
        logic               deg;
        logic               nd;
        logic               last;
        logic [RATE_W-1:0]  budget;
        logic [REQ_W-1:0]   req;
        logic [RATE_W-1:0]  used;
    } grant_t;

    typedef struct packed {
        logic               cmd;
        logic [SLOTF_W-1:0] slot;
        logic [PRIO_W-1:0]  prio;
        logic [RATE_W-1:0]  rate;
        logic               en;
        logic               typed;
        grant_t             known;
    } row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_LONG} rx_mode_t;

    localparam grant_t NO_WORD = '0;
    localparam grant_t IDLE_WIRED = '{slot: 4'd0, prio: 3'd0, grant: 16'd0, deg: 1'b0,
                                      nd: 1'b1, last: 1'b1, budget: WIRED_DEFAULT,
                                      req: 20'd0, used: 16'd0};
    // one slot asking for the full rate range against the default wired budget
    localparam grant_t CAPPED_FIRST = '{slot: 4'd0, prio: 3'd0, grant: WIRED_DEFAULT,
                                        deg: 1'b1, nd: 1'b0, last: 1'b1,
                                        budget: WIRED_DEFAULT, req: 20'd65535,
                                        used: WIRED_DEFAULT};

    localparam int PLAN_ROWS = 21;
    localparam row_t PLAN [0:PLAN_ROWS-1] = '{
        '{CMD_COMPUTE, 4'd0,  3'd0, 16'd0,     1'b0, 1'b1, IDLE_WIRED},
        '{CMD_WRITE,   4'd0,  3'd0, 16'hFFFF,  1'b1, 1'b0, NO_WORD},
        '{CMD_COMPUTE, 4'd0,  3'd0, 16'd0,     1'b0, 1'b1, CAPPED_FIRST},
        // zero rate with enable set still counts as no demand
        '{CMD_WRITE,   4'd0,  3'd0, 16'd0,     1'b1, 1'b0, NO_WORD},
        '{CMD_COMPUTE, 4'd15, 3'd7, 16'hFFFF,  1'b1, 1'b1, IDLE_WIRED},
        '{CMD_WRITE,   4'd15, 3'd7, 16'd100,   1'b1, 1'b0, NO_WORD},
        '{CMD_WRITE,   4'd3,  3'd7, 16'd200,   1'b1, 1'b0, NO_WORD},
        '{CMD_WRITE,   4'd8,  3'd0, 16'd4500,  1'b1, 1'b0, NO_WORD},
        '{CMD_WRITE,   4'd9,  3'd2, 16'd95,    1'b0, 1'b0, NO_WORD},
        // exact fit of the budget
        '{CMD_COMPUTE, 4'd0,  3'd0, 16'd0,     1'b0, 1'b0, NO_WORD},
        '{CMD_WRITE,   4'd9,  3'd2, 16'd95,    1'b1, 1'b0, NO_WORD},
        // last slot sees a remainder below half a Mbps
        '{CMD_COMPUTE, 4'd0,  3'd0, 16'd0,     1'b0, 1'b0, NO_WORD},
        '{CMD_WRITE,   4'd5,  3'd1, 16'd1,     1'b1, 1'b0, NO_WORD},
        '{CMD_WRITE,   4'd12, 3'd5, 16'h8000,  1'b1, 1'b0, NO_WORD},
        '{CMD_COMPUTE, 4'd0,  3'd0, 16'd0,     1'b0, 1'b0, NO_WORD},
        '{CMD_WRITE,   4'd8,  3'd7, 16'hFFFF,  1'b0, 1'b0, NO_WORD},
        '{CMD_COMPUTE, 4'd0,  3'd0, 16'd0,     1'b0, 1'b0, NO_WORD},
        '{CMD_WRITE,   4'd10, 3'd3, 16'h7FFF,  1'b1, 1'b0, NO_WORD},
        '{CMD_WRITE,   4'd7,  3'd4, 16'h00FF,  1'b1, 1'b0, NO_WORD},
        '{CMD_COMPUTE, 4'd0,  3'd0, 16'd0,     1'b0, 1'b0, NO_WORD},
        '{CMD_COMPUTE, 4'd6,  3'd6, 16'h5555,  1'b1, 1'b0, NO_WORD}
    };

    logic                  clk;
    logic                  rst_n;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [RATE_W-1:0]     cfg_data;

    // predictor copy of the demand table and registers
    logic [RATE_W-1:0] slot_rate [SLOTS];
    logic [PRIO_W-1:0] slot_prio [SLOTS];
    logic              slot_on   [SLOTS];
    logic [RATE_W-1:0] wired_cap;
    logic [RATE_W-1:0] wireless_cap;
    logic              on_wireless;

    grant_t grants_due [$];

    int mismatches    = 0;
    int words_sent    = 0;
    int computes_sent = 0;
    int words_checked = 0;
    int reg_writes    = 0;
    int burst_left    = 0;

    rx_mode_t   rx_mode;
    int         rx_mode_left;
    logic [2:0] rx_phase;

    strict_priority_bandwidth_allocator_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // grants in priority order, ties to the lower slot, remainder only above 0.5 Mbps
    function automatic void predict_grants();
        logic [RATE_W-1:0] budget;
        logic [REQ_W:0]    req_sum;
        logic [RATE_W:0]   used;
        logic [RATE_W:0]   want;
        logic [RATE_W:0]   remain;
        grant_t            g;
        int                n;
        budget  = on_wireless ? wireless_cap : wired_cap;
        req_sum = '0;
        used    = '0;
        n       = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_on[i] && slot_rate[i] != 0)
            begin
                req_sum = req_sum + {5'd0, slot_rate[i]};
                if (req_sum > {1'b0, REQ_MAX})
                    req_sum = {1'b0, REQ_MAX};
            end
        end
        for (int p = 0; p < LEVELS; p++)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slot_on[i] || slot_rate[i] == 0 || 32'(slot_prio[i]) != p)
                    continue;
                want  = {1'b0, slot_rate[i]};
                g     = '0;
                g.deg = 1'b0;
                if (used + want > {1'b0, budget})
                begin
                    remain = {1'b0, budget} - used;
                    want   = (remain > {1'b0, MIN_REMAIN}) ? remain : '0;
                    g.deg  = 1'b1;
                end
                used     = used + want;
                g.slot   = SLOTF_W'(i);
                g.prio   = PRIO_W'(p);
                g.grant  = want[RATE_W-1:0];
                g.budget = budget;
                g.req    = req_sum[REQ_W-1:0];
                g.used   = used[RATE_W-1:0];
                grants_due = {grants_due, g};
                n++;
            end
        end
        if (n == 0)
        begin
            g        = '0;
            g.nd     = 1'b1;
            g.budget = budget;
            grants_due = {grants_due, g};
        end
        grants_due[grants_due.size()-1].last = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [REQ_W-1:0] want,
                                        logic [REQ_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // sender bursts: random run lengths, random gaps, sometimes back to back
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic send_word(logic cmd, logic [SLOTF_W-1:0] slot, logic [PRIO_W-1:0] prio,
                             logic [RATE_W-1:0] rate, logic en, logic typed, grant_t known);
        pace();
        s_axis_tdata  <= {en, rate, prio, slot};
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        words_sent++;
        if (cmd == CMD_WRITE)
        begin
            slot_rate[slot] = rate;
            slot_prio[slot] = prio;
            slot_on[slot]   = en;
        end
        else
        begin
            computes_sent++;
            if (typed)
                grants_due = {grants_due, known};
            else
                predict_grants();
        end
    endtask

    // hold the sender until every grant word is back and the block has settled
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (grants_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIRED_BUDGET:    wired_cap    = (val != 0) ? val : WIRED_DEFAULT;
            CFG_WIRELESS_BUDGET: wireless_cap = (val != 0) ? val : WIRELESS_DEFAULT;
            CFG_MODE_WIRELESS:   on_wireless  = val[0];
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    // mostly slot writes with a compute every few words
    task automatic random_words(int count);
        logic              cmd;
        logic [RATE_W-1:0] rate;
        for (int k = 0; k < count; k++)
        begin
            cmd = ($urandom_range(0, 4) == 0) ? CMD_COMPUTE : CMD_WRITE;
            case ($urandom_range(0, 9))
                0:          rate = '0;
                1:          rate = '1;
                2, 3, 4, 5: rate = RATE_W'($urandom_range(1, 400));
                6, 7:       rate = RATE_W'($urandom_range(1, 2500));
                default:    rate = RATE_W'($urandom);
            endcase
            send_word(cmd, SLOTF_W'($urandom_range(0, SLOTS - 1)),
                      PRIO_W'($urandom_range(0, LEVELS - 1)), rate,
                      $urandom_range(0, 4) != 0, 1'b0, NO_WORD);
        end
    endtask

    // receiver stall pattern, switching to a random style whenever its run counter runs out
    always @(posedge clk)
    begin
        rx_phase <= rx_phase + 3'd1;
        if (rx_mode_left == 0)
        begin
            rx_mode      <= rx_mode_t'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(50, 300);
        end
        else
        begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= ($urandom_range(0, 1) != 0);
            RX_PERIODIC: m_axis_tready <= (rx_phase < 3'd5);
            default:     m_axis_tready <= ($urandom_range(0, 15) != 0) ? m_axis_tready
                                                                      : ~m_axis_tready;
        endcase
    end

    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_checked++;
            if (grants_due.size() == 0)
            begin
                $display("%0t: grant word with none expected, tdata %h", $time, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = grants_due.pop_front();
                check_field("grant_slot",      want.slot,   m_axis_tdata[3:0]);
                check_field("grant_priority",  want.prio,   m_axis_tdata[6:4]);
                check_field("grant_rate",      want.grant,  m_axis_tdata[22:7]);
                check_field("degraded",        want.deg,    m_axis_tdata[23]);
                check_field("no_demand",       want.nd,     m_axis_tuser[0]);
                check_field("last",            want.last,   m_axis_tlast);
                check_field("total_budget",    want.budget, m_axis_tdata[39:24]);
                check_field("requested_total", want.req,    m_axis_tdata[59:40]);
                check_field("used_total",      want.used,   m_axis_tdata[75:60]);
            end
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tvalid <= 1'b0;
        m_axis_tready <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        rx_mode       <= RX_OPEN;
        rx_mode_left  <= 0;
        rx_phase      <= '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_rate[i] = '0;
            slot_prio[i] = '0;
            slot_on[i]   = 1'b0;
        end
        wired_cap    = WIRED_DEFAULT;
        wireless_cap = WIRELESS_DEFAULT;
        on_wireless  = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < PLAN_ROWS; k++)
            send_word(PLAN[k].cmd, PLAN[k].slot, PLAN[k].prio, PLAN[k].rate, PLAN[k].en,
                      PLAN[k].typed, PLAN[k].known);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0: write_reg(CFG_WIRED_BUDGET, 16'd1);
                1: write_reg(CFG_WIRED_BUDGET, 16'hFFFF);
                2:
                begin
                    write_reg(CFG_WIRELESS_BUDGET, 16'd1);
                    write_reg(CFG_MODE_WIRELESS, 16'd1);
                end
                3:
                begin
                    write_reg(CFG_WIRELESS_BUDGET, 16'hFFFF);
                    write_reg(CFG_MODE_WIRELESS, 16'hFFFF);
                end
                4:
                begin
                    // zero budgets fall back to the defaults; upper mode bits are don't care
                    write_reg(CFG_WIRED_BUDGET, 16'd0);
                    write_reg(CFG_WIRELESS_BUDGET, 16'd0);
                    write_reg(CFG_MODE_WIRELESS, 16'hFFFE);
                    write_reg(CFG_SPARE, RATE_W'($urandom));
                end
                5: write_reg(CFG_MODE_WIRELESS, 16'd1);
                default:
                begin
                    write_reg(CFG_WIRED_BUDGET, RATE_W'($urandom_range(1, 65535)));
                    write_reg(CFG_WIRELESS_BUDGET, RATE_W'($urandom_range(1, 65535)));
                    write_reg(CFG_MODE_WIRELESS, RATE_W'($urandom));
                end
            endcase
            random_words(PHASE_WORDS);
        end

        wait_idle();
        $display("sent %0d stimulus words (%0d computes) across %0d register writes",
                 words_sent, computes_sent, reg_writes);
        $display("checked %0d grant words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/spba_pkg.sv
rtl/core/spba_ram.sv
rtl/core/strict_priority_bandwidth_allocator_core.sv
sim/strict_priority_bandwidth_allocator_core_test.sv
